FILE: sv/rbc_pkg.sv
// Shared types, constants and arithmetic helpers for the RNS binary converter.
package rbc_pkg;

   localparam int DATA_W = 64;
   localparam int WIDE_W = 2 * DATA_W;
   localparam int NUM_MODULI = 3;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_1 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_2 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_MOD_THIRD = 3'd5;

   localparam logic CMD_FORWARD = 1'b0;
   localparam logic CMD_REVERSE = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [DATA_W-1:0] coeff_low;
      logic [DATA_W-1:0] coeff_high;
      logic [DATA_W-1:0] residue_in_0;
      logic [DATA_W-1:0] residue_in_1;
      logic [DATA_W-1:0] residue_in_2;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] residue_out_0;
      logic [DATA_W-1:0] residue_out_1;
      logic [DATA_W-1:0] residue_out_2;
      logic [DATA_W-1:0] value_low;
      logic [DATA_W-1:0] value_high;
   } rsp_type;

   typedef struct packed {
      logic                              cmd;
      logic [DATA_W-1:0]                 r4;
      logic [DATA_W-1:0]                 r5;
      logic [DATA_W-1:0]                 t0;
      logic [DATA_W-1:0]                 c2;
      logic [DATA_W-1:0]                 t1;
      logic [NUM_MODULI-1:0][DATA_W-1:0] fwd;
      logic [WIDE_W-1:0]                 t1m0;
   } item_type;

   function automatic logic [DATA_W-1:0] mod_step(input logic [DATA_W-1:0] r,
                                                  input logic b,
                                                  input logic [DATA_W-1:0] m);
      logic [DATA_W:0] t;
      logic [DATA_W:0] d;
      t = {r, b};
      d = t - {1'b0, m};
      mod_step = (t >= {1'b0, m}) ? d[DATA_W-1:0] : t[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] sub_mod(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] c,
                                                 input logic [DATA_W-1:0] m);
      sub_mod = (a < c) ? (a + (m - c)) : (a - c);
   endfunction

   function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b,
                                                 input logic [DATA_W-1:0] m);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (m == '0) begin
         add_mod = s[DATA_W-1:0];
      end else if (s[DATA_W] || (s[DATA_W-1:0] >= m)) begin
         add_mod = s[DATA_W-1:0] - m;
      end else begin
         add_mod = s[DATA_W-1:0];
      end
   endfunction

endpackage

FILE: sv/rns_binary_converter_garner.sv
// Top level of the RNS binary converter: forward reduction and Garner reconstruction.
// Throughput is one word per cycle while no result word is held under rsp_stall.
// The bit-serial reduction chains set the depth of the pipeline.
// The whole pipeline holds while a result word waits under rsp_stall.
// Synchronous active-high reset clears all valid bits and loads the register defaults.
// The configuration registers reset to moduli of two, inverses of one and a zero weight.
module rns_binary_converter_garner (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rbc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rbc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_enable,
   input  logic [rbc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rbc_pkg::DATA_W-1:0]         csr_data
);

   localparam int DW = rbc_pkg::DATA_W;
   localparam int IW = $bits(rbc_pkg::item_type);

   logic [DW-1:0] modulus_0_ff, modulus_1_ff, modulus_2_ff;
   logic [DW-1:0] inverse_1_ff, inverse_2_ff, first_mod_third_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_0_ff       <= DW'(2);
         modulus_1_ff       <= DW'(2);
         modulus_2_ff       <= DW'(2);
         inverse_1_ff       <= DW'(1);
         inverse_2_ff       <= DW'(1);
         first_mod_third_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rbc_pkg::CSR_MODULUS_0:       modulus_0_ff <= csr_data;
            rbc_pkg::CSR_MODULUS_1:       modulus_1_ff <= csr_data;
            rbc_pkg::CSR_MODULUS_2:       modulus_2_ff <= csr_data;
            rbc_pkg::CSR_INVERSE_1:       inverse_1_ff <= csr_data;
            rbc_pkg::CSR_INVERSE_2:       inverse_2_ff <= csr_data;
            rbc_pkg::CSR_FIRST_MOD_THIRD: first_mod_third_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;
   rbc_pkg::rsp_type rsp_ff, rsp_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // Forward reduction and first Garner digit run side by side.
   rbc_pkg::item_type entry_item, f_item;
   logic f_valid;
   logic [rbc_pkg::NUM_MODULI-1:0][DW-1:0] f_rem;

   always_comb begin
      entry_item     = '0;
      entry_item.r4  = req_data.residue_in_1;
      entry_item.r5  = req_data.residue_in_2;
   end

   rbc_modred #(.DIV_W(rbc_pkg::WIDE_W), .LANES(rbc_pkg::NUM_MODULI), .SIDE_W(IW)) u_fwd (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .in_div({req_data.coeff_high, req_data.coeff_low}),
      .modulus({modulus_2_ff, modulus_1_ff, modulus_0_ff}),
      .in_side(entry_item),
      .out_valid(f_valid), .out_rem(f_rem), .out_side(f_item)
   );

   logic a_valid, a_cmd;
   logic [0:0][DW-1:0] a_rem;

   rbc_modred #(.DIV_W(DW), .LANES(1), .SIDE_W(1)) u_t0 (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .in_div(req_data.residue_in_0), .modulus(modulus_0_ff),
      .in_side(req_data.cmd),
      .out_valid(a_valid), .out_rem(a_rem), .out_side(a_cmd)
   );

   logic b_valid;
   logic [1:0][DW-1:0] b_rem;
   logic [DW:0] b_side;

   rbc_modred #(.DIV_W(DW), .LANES(2), .SIDE_W(DW + 1)) u_carry (
      .clock(clock), .reset(reset), .en(en), .in_valid(a_valid),
      .in_div(a_rem[0]), .modulus({modulus_2_ff, modulus_1_ff}),
      .in_side({a_cmd, a_rem[0]}),
      .out_valid(b_valid), .out_rem(b_rem), .out_side(b_side)
   );

   // First digit difference.
   rbc_pkg::item_type p0_item_ff, p0_item_in;
   logic [DW-1:0] p0_a_ff;
   logic p0_valid_ff;

   always_comb begin
      p0_item_in     = f_item;
      p0_item_in.cmd = b_side[DW];
      p0_item_in.t0  = b_side[DW-1:0];
      p0_item_in.c2  = b_rem[1];
      p0_item_in.fwd = f_rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (en) begin
         p0_valid_ff <= f_valid && b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_item_ff <= p0_item_in;
         p0_a_ff    <= rbc_pkg::sub_mod(f_item.r4, b_rem[0], modulus_1_ff);
      end
   end

   // t1 = (r1 - c1) * inverse_1 mod m1.
   logic m1_valid;
   logic [0:0][rbc_pkg::WIDE_W-1:0] m1_prod;
   rbc_pkg::item_type m1_item;

   rbc_mul64 #(.LANES(1), .SIDE_W(IW)) u_mul_t1 (
      .clock(clock), .reset(reset), .en(en), .in_valid(p0_valid_ff),
      .in_a(p0_a_ff), .in_b(inverse_1_ff), .in_side(p0_item_ff),
      .out_valid(m1_valid), .out_prod(m1_prod), .out_side(m1_item)
   );

   logic r1_valid;
   logic [0:0][DW-1:0] r1_rem;
   rbc_pkg::item_type r1_item, r1_item_t1;

   rbc_modred #(.DIV_W(rbc_pkg::WIDE_W), .LANES(1), .SIDE_W(IW)) u_red_t1 (
      .clock(clock), .reset(reset), .en(en), .in_valid(m1_valid),
      .in_div(m1_prod[0]), .modulus(modulus_1_ff), .in_side(m1_item),
      .out_valid(r1_valid), .out_rem(r1_rem), .out_side(r1_item)
   );

   always_comb begin
      r1_item_t1    = r1_item;
      r1_item_t1.t1 = r1_rem[0];
   end

   // Carry into the third digit: t1 * first_mod_third mod m2.
   logic m2_valid;
   logic [0:0][rbc_pkg::WIDE_W-1:0] m2_prod;
   rbc_pkg::item_type m2_item;

   rbc_mul64 #(.LANES(1), .SIDE_W(IW)) u_mul_carry (
      .clock(clock), .reset(reset), .en(en), .in_valid(r1_valid),
      .in_a(r1_rem[0]), .in_b(first_mod_third_ff), .in_side(r1_item_t1),
      .out_valid(m2_valid), .out_prod(m2_prod), .out_side(m2_item)
   );

   logic r2_valid;
   logic [0:0][DW-1:0] r2_rem;
   rbc_pkg::item_type r2_item;

   rbc_modred #(.DIV_W(rbc_pkg::WIDE_W), .LANES(1), .SIDE_W(IW)) u_red_carry (
      .clock(clock), .reset(reset), .en(en), .in_valid(m2_valid),
      .in_div(m2_prod[0]), .modulus(modulus_2_ff), .in_side(m2_item),
      .out_valid(r2_valid), .out_rem(r2_rem), .out_side(r2_item)
   );

   rbc_pkg::item_type p1_item_ff, p1_item_in, p2_item_ff;
   logic p1_valid_ff, p2_valid_ff;
   logic [DW-1:0] p2_a_ff;

   always_comb begin
      p1_item_in    = r2_item;
      p1_item_in.c2 = rbc_pkg::add_mod(r2_item.c2, r2_rem[0], modulus_2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= r2_valid;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_item_ff <= p1_item_in;
         p2_item_ff <= p1_item_ff;
         p2_a_ff    <= rbc_pkg::sub_mod(p1_item_ff.r5, p1_item_ff.c2, modulus_2_ff);
      end
   end

   // t2 = (r2 - c2) * inverse_2 mod m2.
   logic m3_valid;
   logic [0:0][rbc_pkg::WIDE_W-1:0] m3_prod;
   rbc_pkg::item_type m3_item;

   rbc_mul64 #(.LANES(1), .SIDE_W(IW)) u_mul_t2 (
      .clock(clock), .reset(reset), .en(en), .in_valid(p2_valid_ff),
      .in_a(p2_a_ff), .in_b(inverse_2_ff), .in_side(p2_item_ff),
      .out_valid(m3_valid), .out_prod(m3_prod), .out_side(m3_item)
   );

   logic r3_valid;
   logic [0:0][DW-1:0] r3_rem;
   rbc_pkg::item_type r3_item;

   rbc_modred #(.DIV_W(rbc_pkg::WIDE_W), .LANES(1), .SIDE_W(IW)) u_red_t2 (
      .clock(clock), .reset(reset), .en(en), .in_valid(m3_valid),
      .in_div(m3_prod[0]), .modulus(modulus_2_ff), .in_side(m3_item),
      .out_valid(r3_valid), .out_rem(r3_rem), .out_side(r3_item)
   );

   // Mixed-radix weights: t2 * m0 and t1 * m0, then (t2 * m0) * m1.
   logic m4_valid;
   logic [1:0][rbc_pkg::WIDE_W-1:0] m4_prod;
   rbc_pkg::item_type m4_item, m4_item_w;

   rbc_mul64 #(.LANES(2), .SIDE_W(IW)) u_mul_w0 (
      .clock(clock), .reset(reset), .en(en), .in_valid(r3_valid),
      .in_a({r3_item.t1, r3_rem[0]}), .in_b({modulus_0_ff, modulus_0_ff}),
      .in_side(r3_item),
      .out_valid(m4_valid), .out_prod(m4_prod), .out_side(m4_item)
   );

   always_comb begin
      m4_item_w      = m4_item;
      m4_item_w.t1m0 = m4_prod[1];
   end

   logic m5_valid;
   logic [1:0][rbc_pkg::WIDE_W-1:0] m5_prod;
   rbc_pkg::item_type m5_item;

   rbc_mul64 #(.LANES(2), .SIDE_W(IW)) u_mul_w1 (
      .clock(clock), .reset(reset), .en(en), .in_valid(m4_valid),
      .in_a({m4_prod[0][rbc_pkg::WIDE_W-1:DW], m4_prod[0][DW-1:0]}),
      .in_b({modulus_1_ff, modulus_1_ff}),
      .in_side(m4_item_w),
      .out_valid(m5_valid), .out_prod(m5_prod), .out_side(m5_item)
   );

   logic f1_valid_ff;
   rbc_pkg::item_type f1_item_ff;
   logic [rbc_pkg::WIDE_W-1:0] f1_part_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= m5_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_item_ff <= m5_item;
         f1_part_ff <= {m5_prod[0][rbc_pkg::WIDE_W-1:DW] + m5_prod[1][DW-1:0],
                        m5_prod[0][DW-1:0]};
      end
   end

   logic [rbc_pkg::WIDE_W-1:0] value_sum;

   always_comb begin
      value_sum = {{DW{1'b0}}, f1_item_ff.t0} + f1_item_ff.t1m0 + f1_part_ff;
      rsp_in    = '0;
      if (f1_item_ff.cmd == rbc_pkg::CMD_REVERSE) begin
         rsp_in.value_low  = value_sum[DW-1:0];
         rsp_in.value_high = value_sum[rbc_pkg::WIDE_W-1:DW];
      end else begin
         rsp_in.residue_out_0 = f1_item_ff.fwd[0];
         rsp_in.residue_out_1 = f1_item_ff.fwd[1];
         rsp_in.residue_out_2 = f1_item_ff.fwd[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: sv/rbc_modred.sv
// Bit-serial pipelined reduction of a wide dividend by per-lane moduli, one bit per stage.
module rbc_modred #(
   parameter int DIV_W = 128,
   parameter int LANES = 1,
   parameter int SIDE_W = 1
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       en,
   input  logic                                       in_valid,
   input  logic [DIV_W-1:0]                           in_div,
   input  logic [LANES-1:0][rbc_pkg::DATA_W-1:0]      modulus,
   input  logic [SIDE_W-1:0]                          in_side,
   output logic                                       out_valid,
   output logic [LANES-1:0][rbc_pkg::DATA_W-1:0]      out_rem,
   output logic [SIDE_W-1:0]                          out_side
);

   logic [LANES-1:0][rbc_pkg::DATA_W-1:0] rem_ff  [DIV_W];
   logic [LANES-1:0][rbc_pkg::DATA_W-1:0] rem_cur [DIV_W];
   logic [LANES-1:0][rbc_pkg::DATA_W-1:0] rem_in  [DIV_W];
   logic [DIV_W-1:0]                      div_ff  [DIV_W];
   logic [DIV_W-1:0]                      div_cur [DIV_W];
   logic [SIDE_W-1:0]                     side_ff [DIV_W];
   logic [DIV_W-1:0]                      valid_ff;

   always_comb begin
      div_cur[0] = in_div;
      rem_cur[0] = '0;
      for (int k = 1; k < DIV_W; k++) begin
         div_cur[k] = div_ff[k-1];
         rem_cur[k] = rem_ff[k-1];
      end
      for (int k = 0; k < DIV_W; k++) begin
         for (int l = 0; l < LANES; l++) begin
            rem_in[k][l] = rbc_pkg::mod_step(rem_cur[k][l], div_cur[k][DIV_W-1], modulus[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < DIV_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = 0; k < DIV_W; k++) begin
            rem_ff[k] <= rem_in[k];
            div_ff[k] <= div_cur[k] << 1;
         end
      end
   end

   assign out_valid = valid_ff[DIV_W-1];
   assign out_rem   = rem_ff[DIV_W-1];
   assign out_side  = side_ff[DIV_W-1];

endmodule

FILE: sv/rbc_mul64.sv
// Two-stage 64-by-64 multiplier built from four 32-by-32 partial products per lane.
module rbc_mul64 #(
   parameter int LANES = 1,
   parameter int SIDE_W = 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic [LANES-1:0][rbc_pkg::DATA_W-1:0]  in_a,
   input  logic [LANES-1:0][rbc_pkg::DATA_W-1:0]  in_b,
   input  logic [SIDE_W-1:0]                      in_side,
   output logic                                   out_valid,
   output logic [LANES-1:0][rbc_pkg::WIDE_W-1:0]  out_prod,
   output logic [SIDE_W-1:0]                      out_side
);

   localparam int HALF_W = rbc_pkg::DATA_W / 2;

   logic [LANES-1:0][rbc_pkg::DATA_W-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [LANES-1:0][rbc_pkg::WIDE_W-1:0] prod_ff, prod_in;
   logic [SIDE_W-1:0]                     side_ff [2];
   logic [1:0]                            valid_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         prod_in[l] = {p11_ff[l], p00_ff[l]}
                    + {{HALF_W{1'b0}}, p01_ff[l], {HALF_W{1'b0}}}
                    + {{HALF_W{1'b0}}, p10_ff[l], {HALF_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            p00_ff[l] <= in_a[l][HALF_W-1:0] * in_b[l][HALF_W-1:0];
            p01_ff[l] <= in_a[l][HALF_W-1:0] * in_b[l][rbc_pkg::DATA_W-1:HALF_W];
            p10_ff[l] <= in_a[l][rbc_pkg::DATA_W-1:HALF_W] * in_b[l][HALF_W-1:0];
            p11_ff[l] <= in_a[l][rbc_pkg::DATA_W-1:HALF_W] * in_b[l][rbc_pkg::DATA_W-1:HALF_W];
         end
         prod_ff    <= prod_in;
         side_ff[0] <= in_side;
         side_ff[1] <= side_ff[0];
      end
   end

   assign out_valid = valid_ff[1];
   assign out_prod  = prod_ff;
   assign out_side  = side_ff[1];

endmodule

FILE: sv/rbc_checker.sv
// Port-level checker for the RNS binary converter and its bind statement.
module rbc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rbc_pkg::rsp_type rsp_data
);

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("Stalled result word changed.");

   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("Input stalled while the result side is free.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_data.value_low != '0) || (rsp_data.value_high != '0)))
      |-> ((rsp_data.residue_out_0 == '0) && (rsp_data.residue_out_1 == '0)
           && (rsp_data.residue_out_2 == '0)))
      else $error("Result word mixes residues and a reconstructed value.");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("Input stalled without a held result word.");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> req_valid)
      else $error("Stalled input word was withdrawn.");

endmodule

bind rns_binary_converter_garner rbc_checker u_rbc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);
